>>> rtl/mwc_pkg.sv
// ----------------------------------------------------------------------------
// mwc_pkg: shared types and constants of the multiply-with-carry generator
// Step constants, seed reset values, register indexes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mwc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [HALF_W-1:0] Z_MUL   = 16'd36969;
  localparam logic [HALF_W-1:0] W_MUL   = 16'd18000;
  localparam logic [DATA_W-1:0] W_RESET = 32'd521288629;
  localparam logic [DATA_W-1:0] Z_RESET = 32'd362436069;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_W = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_Z = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_direct;
    logic start_div;
    logic div_step;
    logic load_div;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } status_t;

  function automatic logic [DATA_W-1:0] mwc_advance(input logic [DATA_W-1:0] x,
                                                     input logic [HALF_W-1:0] mul);
    logic [DATA_W-1:0] prod;
    prod = DATA_W'(x[HALF_W-1:0]) * DATA_W'(mul);
    return prod + DATA_W'(x[DATA_W-1:HALF_W]);
  endfunction

endpackage

`default_nettype wire

>>> rtl/mwc_datapath.sv
// ----------------------------------------------------------------------------
// mwc_datapath: generator halves, restoring remainder unit, result register
// Holds the w and z halves, advances them on a draw, reduces a ranged draw
// one quotient bit per cycle and keeps the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mwc_datapath
  import mwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata,
  input  wire logic                 func,
  input  wire logic [DATA_W-1:0]    lower,
  input  wire logic [DATA_W-1:0]    upper,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  output logic [DATA_W-1:0]         value,
  output logic                      bad_range,
  input  wire logic                 rst_n
);

  logic [DATA_W-1:0] w_r, w_nxt;
  logic [DATA_W-1:0] z_r, z_nxt;
  logic [DATA_W-1:0] w_adv, z_adv, draw;
  logic [DATA_W-1:0] lower_r, span_r, dvd_r, rem_r;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] value_r;
  logic              bad_r;
  logic              advance;

  assign w_adv = mwc_advance(w_r, W_MUL);
  assign z_adv = mwc_advance(z_r, Z_MUL);
  assign draw  = {z_adv[HALF_W-1:0], {HALF_W{1'b0}}} + w_adv;

  assign advance = (cmd.load_direct && !func) || cmd.start_div;

  assign status.div_needed = func && (lower < upper);
  assign status.div_last   = (cnt_r == CNT_W'(DIV_STEPS - 1));

  assign rem_sh  = {rem_r, dvd_r[DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, span_r};

  always_comb begin
    w_nxt = w_r;
    z_nxt = z_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED_W: w_nxt = cfg_wdata;
        CFG_SEED_Z: if (cfg_wdata != '0) z_nxt = cfg_wdata;
        default: ;
      endcase
    end else if (advance) begin
      w_nxt = w_adv;
      z_nxt = z_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= W_RESET;
      z_r <= Z_RESET;
    end else begin
      w_r <= w_nxt;
      z_r <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      lower_r <= lower;
      span_r  <= upper - lower;
      dvd_r   <= draw;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DATA_W-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_W'(1);
      if (!rem_sub[DATA_W]) rem_r <= rem_sub[DATA_W-1:0];
      else                  rem_r <= rem_sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      value_r <= func ? lower : draw;
      bad_r   <= func && (lower > upper);
    end else if (cmd.load_div) begin
      value_r <= lower_r + rem_r;
      bad_r   <= 1'b0;
    end
  end

  assign value     = value_r;
  assign bad_range = bad_r;

endmodule

`default_nettype wire

>>> rtl/mwc_ctrl.sv
// ----------------------------------------------------------------------------
// mwc_ctrl: request sequencer
// Accepts one request at a time, runs the remainder steps of a ranged draw
// and owns the result valid flag of the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwc_ctrl
  import mwc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept && status.div_needed) state_nxt = ST_DIV;
      ST_DIV:    if (status.div_last) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready       = out_free;
        cmd.load_direct = accept && !status.div_needed;
        cmd.start_div   = accept && status.div_needed;
      end
      ST_DIV:    cmd.div_step = 1'b1;
      ST_FINISH: cmd.load_div = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.load_direct || cmd.load_div) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/mwc_random_with_range_unit.sv
// ----------------------------------------------------------------------------
// mwc_random_with_range_unit: dual 16-bit multiply-with-carry generator
// Raw draws, ranged draws in [lower, upper) and degenerate ranges that return
// lower, with seed registers for both halves.
// ----------------------------------------------------------------------------
// Sequence: a raw or degenerate request is registered straight into the output; a ranged
// request runs accept with generator step, 32 restoring remainder steps, final add.
// Throughput: one request per cycle for raw draws while the output is not stalled;
// a ranged draw holds off new requests through the one-bit-per-cycle remainder unit.
// Reset: synchronous, active low; halves return to their seed reset values,
// the output register is emptied and the sequencer goes idle.
`default_nettype none

module mwc_random_with_range_unit
  import mwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [63:0]          in_tdata,  // lower[31:0], upper[63:32]
  input  wire logic [0:0]           in_tuser,  // func[0]
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata, // value[31:0]
  output logic [0:0]                out_tuser  // bad_range[0]
);

  cmd_t    cmd;
  status_t status;

  mwc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mwc_datapath u_datapath (
    .clk       (clk),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .func      (in_tuser[0]),
    .lower     (in_tdata[31:0]),
    .upper     (in_tdata[63:32]),
    .cmd       (cmd),
    .status    (status),
    .value     (out_tdata),
    .bad_range (out_tuser[0]),
    .rst_n     (rst_n)
  );

endmodule

`default_nettype wire

>>> rtl/mwc_checker.sv
// ----------------------------------------------------------------------------
// mwc_checker: port-level checks of the generator
// Output hold under stall, degenerate range results and busy ranged draws.
// ----------------------------------------------------------------------------
`default_nettype none

module mwc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [63:0] in_tdata,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transfer changed while stalled");

  a_bad_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser[0] && (in_tdata[31:0] > in_tdata[63:32])
    |=> out_tvalid && out_tuser[0] && (out_tdata == $past(in_tdata[31:0])))
    else $error("inverted range did not return lower with flag");

  a_equal_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser[0] && (in_tdata[31:0] == in_tdata[63:32])
    |=> out_tvalid && !out_tuser[0] && (out_tdata == $past(in_tdata[31:0])))
    else $error("empty range did not return lower");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser[0] && (in_tdata[31:0] < in_tdata[63:32]) |=> !in_tready)
    else $error("request taken during ranged draw");

endmodule

bind mwc_random_with_range_unit mwc_checker u_mwc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
